### hw/rtl/fem_pkg.sv
// Shared widths, constants, tables and types of the fisheye map generator.
package fem_pkg;

	// Field widths of the channels and the configuration port.
	localparam int COORD_W    = 12;
	localparam int OUT_W      = 16;
	localparam int DIM_CFG_W  = 13;
	localparam int FOV_W      = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// Fixed-point layout of the datapath.
	localparam int FRAC_W       = 16;
	localparam int DATA_W       = 20;
	localparam int POL_MAG_W    = 19;
	localparam int SPLIT_W      = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

	// Square root unit: radicand width, one root bit per step.
	localparam int SQ_W     = 36;
	localparam int SQ_STEPS = SQ_W / 2;
	localparam int ROOT_W   = SQ_STEPS;

	// Default limit for the fisheye dimensions.
	localparam int DEF_MAX_DIM = 4096;

	// Angle constants in Q16 radians and the CORDIC gain.
	localparam logic signed [DATA_W-1:0] PI_Q        = 20'sd205887;
	localparam logic signed [DATA_W-1:0] HALF_PI_Q   = 20'sd102944;
	localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 20'sd39797;

	// Arctangent of 2^-i in Q16 radians.
	localparam logic signed [DATA_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
		20'sd16, 20'sd8, 20'sd4, 20'sd2
	};

	// Register reset values.
	localparam logic [DIM_CFG_W-1:0] RST_SRC_WIDTH  = 13'd2048;
	localparam logic [DIM_CFG_W-1:0] RST_SRC_HEIGHT = 13'd2048;
	localparam logic [FOV_W-1:0]     RST_FOV        = 19'd205879;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_FOV        = 2'd2
	} cfg_reg_t;

	// One finished coordinate pair.
	typedef struct packed {
		logic signed [OUT_W-1:0] src_x;
		logic signed [OUT_W-1:0] src_y;
	} coord_t;

endpackage

### hw/rtl/fem_if.sv
// Request channel interfaces for pixel coordinates in and source coordinates out.
interface fem_in_if import fem_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;

	modport source (output valid, output out_col, output out_row, input ready);
	modport sink (input valid, input out_col, input out_row, output ready);
endinterface

interface fem_out_if import fem_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] src_x;
	logic signed [OUT_W-1:0] src_y;

	modport source (output valid, output src_x, output src_y, input ready);
	modport sink (input valid, input src_x, input src_y, output ready);
endinterface

### hw/rtl/fem_delay.sv
// Shift line that carries a word a fixed number of pipeline steps.
module fem_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [D];

	// Every tap moves one place when the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < D; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[D-1];

endmodule

### hw/rtl/fem_div.sv
// Pipelined restoring divider, one quotient bit per cell.
module fem_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_cell
		logic [DEN_W-1:0] rp;
		logic [NUM_W-1:0] np;
		logic [DEN_W:0]   t;

		if (k == 0) begin : g_first
			assign rp = '0;
			assign np = num;
		end else begin : g_next
			assign rp = rem_s[k-1];
			assign np = nq_s[k-1];
		end

		// Bring down the next dividend bit and try one subtraction.
		assign t = {rp, np[NUM_W-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, den}) begin
					rem_s[k] <= DEN_W'(t - {1'b0, den});
					nq_s[k]  <= {np[NUM_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= t[DEN_W-1:0];
					nq_s[k]  <= {np[NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

### hw/rtl/fem_isqrt.sv
// Pipelined integer square root, one root bit per cell.
module fem_isqrt import fem_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   rad,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_s   [SQ_STEPS];
	logic [SQ_W+1:0] res_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
		localparam logic [SQ_W+1:0] BIT = (SQ_W+2)'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_W-1:0] vp;
		logic [SQ_W+1:0] rp;
		logic [SQ_W+1:0] cmp;

		if (k == 0) begin : g_first
			assign vp = rad;
			assign rp = '0;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign rp = res_s[k-1];
		end

		assign cmp = rp + BIT;

		// Keep the trial bit when the remainder still covers it.
		always_ff @(posedge clk) begin
			if (en) begin
				if ((SQ_W+2)'(vp) >= cmp) begin
					v_s[k]   <= SQ_W'((SQ_W+2)'(vp) - cmp);
					res_s[k] <= (rp >> 1) + BIT;
				end else begin
					v_s[k]   <= vp;
					res_s[k] <= rp >> 1;
				end
			end
		end
	end

	assign root = res_s[SQ_STEPS-1][ROOT_W-1:0];

endmodule

### hw/rtl/fem_cordic_rot.sv
// Rotation CORDIC chain giving cosine and sine of a Q16 angle.
module fem_cordic_rot import fem_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] ang,
	output logic signed [DATA_W-1:0] cos_v,
	output logic signed [DATA_W-1:0] sin_v
);

	logic signed [DATA_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [DATA_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [DATA_W-1:0] z_s [CORDIC_STEPS+1];
	logic                     n_s [CORDIC_STEPS+1];

	// Fold the angle into the half circle around zero.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			if (ang > HALF_PI_Q) begin
				z_s[0] <= ang - PI_Q;
				n_s[0] <= 1'b1;
			end else if (ang < -HALF_PI_Q) begin
				z_s[0] <= ang + PI_Q;
				n_s[0] <= 1'b1;
			end else begin
				z_s[0] <= ang;
				n_s[0] <= 1'b0;
			end
		end
	end

	// One micro-rotation per cell, direction from the residual angle.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ATAN_TAB[k];
				end
			end
		end
	end

	// Undo the fold by flipping both outputs.
	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= n_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
			sin_v <= n_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		end
	end

endmodule

### hw/rtl/fem_cordic_vec.sv
// Vectoring CORDIC chain giving the Q16 angle atan2(y, x).
module fem_cordic_vec import fem_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic signed [DATA_W-1:0] x_in,
	output logic signed [DATA_W-1:0] ang
);

	logic signed [DATA_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [DATA_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [DATA_W-1:0] z_s [CORDIC_STEPS+1];
	logic                     zr_s [CORDIC_STEPS+1];

	// Mirror the left half plane to the right and start from plus or minus pi.
	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? PI_Q : -PI_Q;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// Each cell drives y toward zero and collects the angle.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[k+1] <= zr_s[k];
				if (y_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ATAN_TAB[k];
				end
			end
		end
	end

	// A zero vector has angle zero.
	always_ff @(posedge clk) begin
		if (en) begin
			ang <= zr_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];
		end
	end

endmodule

### hw/rtl/fisheye_equirect_map_gen.sv
// Top level of the equirectangular to fisheye source coordinate generator.
//
// Each request on pix_in carries one output pixel (out_col, out_row); each
// request on pix_out carries the fisheye coordinate (src_x, src_y) to sample
// for it, in the same order, one result per pixel. The fisheye width, height
// and field of view are set through the cfg_we/cfg_idx/cfg_data write port;
// the user must write them while no pixel is in flight, which the block does not check.
// The datapath is a deep pipeline of small cells: two dividers scale the
// coordinates, rotation CORDIC chains give the sphere point, a square root
// chain and a vectoring CORDIC give the polar angle, a divider turns it into
// a radius, and a second vectoring CORDIC and a third rotation chain give the direction.
// Throughput is one pixel per clock while the output buffer takes results;
// the latency is set by the three dividers and the CORDIC and root chains.
// A two-entry output buffer decouples the pipeline from the receiver: when it
// stalls, the buffer fills and then the whole pipeline holds and pix_in.ready
// drops; nothing is lost. Reset empties the pipeline and buffer and restores
// width 2048, height 2048 and the default field of view.
module fisheye_equirect_map_gen import fem_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fem_in_if.sink                pix_in,
	fem_out_if.source             pix_out
);

	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int NUM1_W    = COORD_W + FRAC_W;
	localparam int NUM2_W    = DIM_W + POL_MAG_W + FRAC_W;
	localparam int R_W       = NUM2_W + 1;
	localparam int HI_W      = R_W - SPLIT_W;
	localparam int SUM_W     = R_W + DATA_W + 2;
	localparam int T_W       = SUM_W - 32;
	localparam int PY_DLY    = 2 + SQ_STEPS;
	localparam int CS_DLY    = 2 + SQ_STEPS + CORDIC_LAT + 1 + NUM2_W + 1 - 2 * CORDIC_LAT;
	localparam int LAT_TOTAL = NUM1_W + 1 + CORDIC_LAT + 1 + 2 + SQ_STEPS + CORDIC_LAT
		+ 1 + NUM2_W + 3;
	localparam logic signed [T_W-1:0] T_MAX = T_W'(32767);
	localparam logic signed [T_W-1:0] T_MIN = T_W'(-32768);

	// Truncate toward zero after dropping 32 fraction bits, then saturate.
	function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [T_W-1:0] t;
		t = v[SUM_W-1:32];
		if (v[SUM_W-1] && (v[31:0] != '0)) t = t + T_W'(1);
		if (t > T_MAX) return OUT_W'(T_MAX);
		if (t < T_MIN) return OUT_W'(T_MIN);
		return t[OUT_W-1:0];
	endfunction

	logic [DIM_CFG_W-1:0] w_q, h_q;
	logic [FOV_W-1:0]     fov_q;
	logic [DIM_W-1:0]     wc, hc;
	logic [FOV_W-1:0]     fc;

	logic en, acc, v_last, push, pop;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	coord_t     buf_q [2];
	coord_t     res_new;

	logic [NUM1_W-1:0]           qlon, qlat;
	logic signed [16:0]          f_lon, f_lat;
	logic signed [DATA_W+16:0]   plon, plat;
	logic signed [DATA_W-1:0]    ang_lon_s1, ang_lat_s1;
	logic signed [DATA_W-1:0]    clon, slon, clat, slat;
	logic signed [2*DATA_W-1:0]  mx, my, sqx, sqz;
	logic signed [DATA_W-1:0]    px_s2, py_s2, pz_s2;
	logic [SQ_W-1:0]             sqx_s3, sqz_s3, sum_s4;
	logic [ROOT_W-1:0]           root;
	logic signed [DATA_W-1:0]    m_ext, az, ca, sa, ca_d, sa_d, py_d, pol;
	logic [DATA_W-1:0]           py_raw;
	logic [2*DATA_W-1:0]         cs_d;
	logic [POL_MAG_W-1:0]        pabs;
	logic [DIM_W+POL_MAG_W-1:0]  wprod_s5;
	logic                        sgn_s5, sgn_d;
	logic [NUM2_W-1:0]           quo;
	logic signed [R_W-1:0]       r_s6;
	logic signed [SPLIT_W+DATA_W:0] pxl_s7, pyl_s7;
	logic signed [HI_W+DATA_W-1:0]  pxh_s7, pyh_s7;
	logic signed [SUM_W-1:0]     vx_s8, vy_s8;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= RST_SRC_WIDTH;
			h_q   <= RST_SRC_HEIGHT;
			fov_q <= RST_FOV;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SRC_WIDTH:  w_q   <= cfg_data[DIM_CFG_W-1:0];
				REG_SRC_HEIGHT: h_q   <= cfg_data[DIM_CFG_W-1:0];
				REG_FOV:        fov_q <= cfg_data[FOV_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero sizes and a zero field of view act as one, large sizes clamp to the limit.
	always_comb begin
		if (w_q == '0) wc = DIM_W'(1);
		else if (32'(w_q) > MAX_DIM) wc = DIM_W'(MAX_DIM);
		else wc = DIM_W'(w_q);
		if (h_q == '0) hc = DIM_W'(1);
		else if (32'(h_q) > MAX_DIM) hc = DIM_W'(MAX_DIM);
		else hc = DIM_W'(h_q);
		fc = (fov_q == '0) ? FOV_W'(1) : fov_q;
	end

	// Pipeline flow: hold only when the output buffer is full and an item waits.
	assign en           = (cnt_q != 2'd2) || !v_last;
	assign acc          = pix_in.valid && en;
	assign pix_in.ready = en;

	fem_delay #(.W(1), .D(LAT_TOTAL)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(acc), .q(v_last)
	);

	// Coordinate fractions: pos * 65536 / size.
	fem_div #(.NUM_W(NUM1_W), .DEN_W(DIM_W)) u_div_lon (
		.clk(clk), .en(en), .num({pix_in.out_col, FRAC_W'(0)}), .den(wc), .quo(qlon)
	);
	fem_div #(.NUM_W(NUM1_W), .DEN_W(DIM_W)) u_div_lat (
		.clk(clk), .en(en), .num({pix_in.out_row, FRAC_W'(0)}), .den(hc), .quo(qlat)
	);

	// Center and wrap the fraction, then scale by pi.
	assign f_lon = qlon[16:0] - 17'd32768;
	assign f_lat = qlat[16:0] - 17'd32768;
	assign plon  = f_lon * PI_Q;
	assign plat  = f_lat * PI_Q;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_lon_s1 <= DATA_W'(plon >>> FRAC_W);
			ang_lat_s1 <= DATA_W'(plat >>> FRAC_W);
		end
	end

	fem_cordic_rot u_rot_lon (
		.clk(clk), .en(en), .ang(ang_lon_s1), .cos_v(clon), .sin_v(slon)
	);
	fem_cordic_rot u_rot_lat (
		.clk(clk), .en(en), .ang(ang_lat_s1), .cos_v(clat), .sin_v(slat)
	);

	// Point on the unit sphere.
	assign mx = clat * slon;
	assign my = clat * clon;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= DATA_W'(mx >>> FRAC_W);
			py_s2 <= DATA_W'(my >>> FRAC_W);
			pz_s2 <= slat;
		end
	end

	// Azimuth of the point and its direction vector.
	fem_cordic_vec u_vec_az (
		.clk(clk), .en(en), .y_in(pz_s2), .x_in(px_s2), .ang(az)
	);
	fem_cordic_rot u_rot_az (
		.clk(clk), .en(en), .ang(az), .cos_v(ca), .sin_v(sa)
	);
	fem_delay #(.W(2 * DATA_W), .D(CS_DLY)) u_cs_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d({ca, sa}), .q(cs_d)
	);
	assign ca_d = cs_d[2*DATA_W-1:DATA_W];
	assign sa_d = cs_d[DATA_W-1:0];

	// Length of the x-z projection.
	assign sqx = px_s2 * px_s2;
	assign sqz = pz_s2 * pz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= sqx[SQ_W-1:0];
			sqz_s3 <= sqz[SQ_W-1:0];
			sum_s4 <= sqx_s3 + sqz_s3;
		end
	end

	fem_isqrt u_isqrt (.clk(clk), .en(en), .rad(sum_s4), .root(root));

	fem_delay #(.W(DATA_W), .D(PY_DLY)) u_py_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(py_s2), .q(py_raw)
	);
	assign py_d  = py_raw;
	assign m_ext = DATA_W'(root);

	// Polar angle from the optical axis.
	fem_cordic_vec u_vec_pol (
		.clk(clk), .en(en), .y_in(m_ext), .x_in(py_d), .ang(pol)
	);

	// Radius numerator: width * |angle|, sign kept aside.
	assign pabs = (pol < 0) ? POL_MAG_W'(-pol) : POL_MAG_W'(pol);

	always_ff @(posedge clk) begin
		if (en) begin
			wprod_s5 <= (DIM_W+POL_MAG_W)'(wc) * (DIM_W+POL_MAG_W)'(pabs);
			sgn_s5   <= pol < 0;
		end
	end

	fem_div #(.NUM_W(NUM2_W), .DEN_W(FOV_W)) u_div_r (
		.clk(clk), .en(en), .num({wprod_s5, FRAC_W'(0)}), .den(fc), .quo(quo)
	);
	fem_delay #(.W(1), .D(NUM2_W)) u_sgn_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sgn_s5), .q(sgn_d)
	);

	// Signed radius, then partial products split at bit 24, then the sums with half the width and height added.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s6   <= sgn_d ? -R_W'(quo) : R_W'(quo);
			pxl_s7 <= $signed({1'b0, r_s6[SPLIT_W-1:0]}) * ca_d;
			pyl_s7 <= $signed({1'b0, r_s6[SPLIT_W-1:0]}) * sa_d;
			pxh_s7 <= $signed(r_s6[R_W-1:SPLIT_W]) * ca_d;
			pyh_s7 <= $signed(r_s6[R_W-1:SPLIT_W]) * sa_d;
			vx_s8  <= (SUM_W'(pxh_s7) <<< SPLIT_W) + SUM_W'(pxl_s7) + (SUM_W'(wc) << 31);
			vy_s8  <= (SUM_W'(pyh_s7) <<< SPLIT_W) + SUM_W'(pyl_s7) + (SUM_W'(hc) << 31);
		end
	end

	// Two-entry output buffer.
	assign res_new.src_x = sat_coord(vx_s8);
	assign res_new.src_y = sat_coord(vy_s8);
	assign push          = en && v_last;
	assign pop           = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= res_new;
	end

	assign pix_out.valid = cnt_q != 2'd0;
	assign pix_out.src_x = buf_q[rd_q].src_x;
	assign pix_out.src_y = buf_q[rd_q].src_y;

	// The buffer never holds more than two results.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	// Input stalls only when the buffer is full and a result waits to enter it.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (cnt_q == 2'd2) && v_last)
		else $error("input stalled without a full output buffer");

	// A held pipeline keeps its last stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_last))
		else $error("last stage changed while the pipeline was held");

endmodule
